// ===== sv/tpsg_pkg.sv =====
// ----------------------------------------------------------------------------
// tpsg_pkg
// Shared types, codes and the quarter-wave sine table of the turtle path
// segment generator.
// ----------------------------------------------------------------------------
package tpsg_pkg;

    localparam int STACK_DEPTH      = 64;
    localparam int SINE_TABLE_DEPTH = 1024;

    localparam int STACK_AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int STACK_CW = $clog2(STACK_DEPTH + 1);
    localparam int SINE_AW  = $clog2(SINE_TABLE_DEPTH);

    // symbol codes
    localparam logic [7:0] SYM_LEFT  = 8'h2B;
    localparam logic [7:0] SYM_RIGHT = 8'h2D;
    localparam logic [7:0] SYM_PUSH  = 8'h28;
    localparam logic [7:0] SYM_POP   = 8'h29;

    // decoded operations
    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_LEFT  = 3'd1;
    localparam logic [2:0] OP_RIGHT = 3'd2;
    localparam logic [2:0] OP_PUSH  = 3'd3;
    localparam logic [2:0] OP_POP   = 3'd4;
    localparam logic [2:0] OP_DRAW  = 3'd5;

    // result kinds
    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_SEGMENT = 2'd1;
    localparam logic [1:0] KIND_DROPPED = 2'd2;

    // register indexes
    localparam logic [2:0] REG_TURN_STEP     = 3'd0;
    localparam logic [2:0] REG_START_HEADING = 3'd1;
    localparam logic [2:0] REG_MASK_LOW      = 3'd2;
    localparam logic [2:0] REG_MASK_MID_LOW  = 3'd3;
    localparam logic [2:0] REG_MASK_MID_HIGH = 3'd4;
    localparam logic [2:0] REG_MASK_HIGH     = 3'd5;

    localparam logic [16:0] Q_ONE = 17'h10000;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [15:0] h;
    } t_frame;

    typedef logic [16:0] t_sine_rom [SINE_TABLE_DEPTH];

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // shift-and-subtract quotient, evaluated only while the table is built
    function automatic longint unsigned quotient(longint unsigned num,
                                                 longint unsigned den);
        longint unsigned q;
        longint unsigned rem;
        q   = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem  = rem - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // round(65536 * sin(k * pi/2 / depth)), truncated Taylor series in Q30
    function automatic t_sine_rom build_sine_rom();
        t_sine_rom      rom;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned r;
        longint         sum;
        for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
            x    = quotient(HALF_PI_Q30 * longint'(k), 64'(SINE_TABLE_DEPTH));
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int n = 1; n <= 10; n++) begin
                term = (term * x2) >> 30;
                term = quotient(term, 64'((2 * n) * (2 * n + 1)));
                if (n[0]) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            r = (longint'(sum) * 65536 + (64'd1 << 29)) >> 30;
            if (r > 65536) begin
                r = 65536;
            end
            rom[k] = r[16:0];
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = build_sine_rom();

endpackage

// ===== sv/turtle_path_segment_generator_core.sv =====
// ----------------------------------------------------------------------------
// turtle_path_segment_generator_core
// Turtle interpreter for expanded L-system strings, one symbol per item.
// ----------------------------------------------------------------------------
// Input stream (s_axis): tdata carries the symbol byte, tuser the string start
// flag. Each accepted item yields exactly one result item on m_axis: tuser is
// the result kind (none, segment, push dropped), tdata the segment end points
// in signed Q15.16 (zero unless a segment was drawn).
// Configuration goes over the APB port, 64-bit registers at 8-byte steps;
// write only while no item is in flight.
// In the accept cycle the sine table (two read
// ports, for sine and cosine) and the stack memory are addressed from the
// current heading and stack count; their registered data arrive in the next
// cycle in the work stage, where the turtle state is updated and the result
// is loaded into the output register once that register is free. The
// read-after-update dependence through the table means a new item is accepted
// only after the work stage has passed its item on.
// A stalled receiver holds the output register; one more item is accepted
// and parked in the work stage, then s_axis_tready stays low.
// Reset clears the pen to the origin, the heading and stack count to zero and
// all configuration registers to zero. No clearing pass is needed.
// ----------------------------------------------------------------------------
module turtle_path_segment_generator_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // input items
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [7:0]    s_axis_tdata,   // [7:0] symbol
    input  logic          s_axis_tuser,   // [0] string_start
    // result items
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [127:0]  m_axis_tdata,   // from_x, from_y, to_x, to_y (32 bits each)
    output logic [1:0]    m_axis_tuser,   // [1:0] result_kind
    // configuration
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [5:0]    paddr,
    input  logic [63:0]   pwdata,
    output logic [63:0]   prdata,
    output logic          pready
);

    localparam int SAW = tpsg_pkg::SINE_AW;
    localparam int KAW = tpsg_pkg::STACK_AW;
    localparam int KCW = tpsg_pkg::STACK_CW;

    // configuration registers
    logic [15:0]  r_turn_step;
    logic [15:0]  r_start_heading;
    logic [63:0]  r_mask0;
    logic [63:0]  r_mask1;
    logic [63:0]  r_mask2;
    logic [63:0]  r_mask3;
    logic [2:0]   cfg_index;
    logic         cfg_write;
    logic [255:0] draw_mask;

    // turtle state
    logic [31:0]    r_x;
    logic [31:0]    r_y;
    logic [15:0]    r_heading;
    logic [KCW-1:0] r_count;
    logic [31:0]    n_x;
    logic [31:0]    n_y;
    logic [15:0]    n_heading;
    logic [KCW-1:0] n_count;

    // stack memory
    tpsg_pkg::t_frame stack_mem [tpsg_pkg::STACK_DEPTH];
    tpsg_pkg::t_frame r_stk_q;
    tpsg_pkg::t_frame stk_wdata;
    logic             stk_we;
    logic [KAW-1:0]   stk_raddr;

    // work stage
    logic        r_s1_valid;
    logic [2:0]  r_s1_op;
    logic        r_s1_start;
    logic [16:0] r_sin_q;
    logic [16:0] r_cos_q;
    logic        r_sin_full;
    logic        r_sin_neg;
    logic        r_cos_full;
    logic        r_cos_neg;

    // output register
    logic         r_out_valid;
    logic [1:0]   r_out_kind;
    logic [127:0] r_out_data;
    logic [1:0]   n_out_kind;
    logic [127:0] n_out_data;

    logic           in_fire;
    logic           s1_fire;
    logic [15:0]    acc_heading;
    logic [15:0]    acc_cos_heading;
    logic [KCW-1:0] acc_count;
    logic [KCW-1:0] acc_count_m1;
    logic [2:0]     acc_op;
    logic [SAW-1:0] sin_idx;
    logic [SAW-1:0] cos_idx;
    logic [SAW-1:0] sin_addr;
    logic [SAW-1:0] cos_addr;

    logic [31:0]    base_x;
    logic [31:0]    base_y;
    logic [15:0]    base_h;
    logic [KCW-1:0] base_count;
    logic [16:0]    sin_mag;
    logic [16:0]    cos_mag;
    logic [17:0]    sin_val;
    logic [17:0]    cos_val;
    logic [32:0]    sum_x;
    logic [32:0]    sum_y;
    logic [31:0]    to_x;
    logic [31:0]    to_y;

    // ------------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_index = paddr[5:3];
    assign cfg_write = psel && penable && pwrite && pready;
    assign draw_mask = {r_mask3, r_mask2, r_mask1, r_mask0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_turn_step     <= '0;
            r_start_heading <= '0;
            r_mask0         <= '0;
            r_mask1         <= '0;
            r_mask2         <= '0;
            r_mask3         <= '0;
        end else if (cfg_write) begin
            unique case (cfg_index)
                tpsg_pkg::REG_TURN_STEP:     r_turn_step     <= pwdata[15:0];
                tpsg_pkg::REG_START_HEADING: r_start_heading <= pwdata[15:0];
                tpsg_pkg::REG_MASK_LOW:      r_mask0         <= pwdata;
                tpsg_pkg::REG_MASK_MID_LOW:  r_mask1         <= pwdata;
                tpsg_pkg::REG_MASK_MID_HIGH: r_mask2         <= pwdata;
                tpsg_pkg::REG_MASK_HIGH:     r_mask3         <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_index)
            tpsg_pkg::REG_TURN_STEP:     prdata = {48'd0, r_turn_step};
            tpsg_pkg::REG_START_HEADING: prdata = {48'd0, r_start_heading};
            tpsg_pkg::REG_MASK_LOW:      prdata = r_mask0;
            tpsg_pkg::REG_MASK_MID_LOW:  prdata = r_mask1;
            tpsg_pkg::REG_MASK_MID_HIGH: prdata = r_mask2;
            tpsg_pkg::REG_MASK_HIGH:     prdata = r_mask3;
            default:                     prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // accept: decode and address the table and stack
    // ------------------------------------------------------------------------
    assign s_axis_tready = !r_s1_valid;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign s1_fire       = r_s1_valid && (!r_out_valid || m_axis_tready);

    assign acc_heading     = s_axis_tuser ? r_start_heading : r_heading;
    assign acc_cos_heading = acc_heading + 16'h4000;
    assign acc_count       = s_axis_tuser ? '0 : r_count;
    assign acc_count_m1    = acc_count - KCW'(1);
    assign stk_raddr       = acc_count_m1[KAW-1:0];

    always_comb begin
        unique case (s_axis_tdata)
            tpsg_pkg::SYM_LEFT:  acc_op = tpsg_pkg::OP_LEFT;
            tpsg_pkg::SYM_RIGHT: acc_op = tpsg_pkg::OP_RIGHT;
            tpsg_pkg::SYM_PUSH:  acc_op = tpsg_pkg::OP_PUSH;
            tpsg_pkg::SYM_POP:   acc_op = tpsg_pkg::OP_POP;
            default: begin
                acc_op = draw_mask[s_axis_tdata] ? tpsg_pkg::OP_DRAW : tpsg_pkg::OP_NONE;
            end
        endcase
    end

    // quarter-wave folding: odd quadrants read the table mirrored
    assign sin_idx  = SAW'(acc_heading[13:0] >> (14 - SAW));
    assign cos_idx  = SAW'(acc_cos_heading[13:0] >> (14 - SAW));
    assign sin_addr = acc_heading[14] ? SAW'(tpsg_pkg::SINE_TABLE_DEPTH - int'(sin_idx))
                                      : sin_idx;
    assign cos_addr = acc_cos_heading[14]
                      ? SAW'(tpsg_pkg::SINE_TABLE_DEPTH - int'(cos_idx)) : cos_idx;

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_sin_q    <= tpsg_pkg::SINE_ROM[sin_addr];
            r_cos_q    <= tpsg_pkg::SINE_ROM[cos_addr];
            r_sin_full <= acc_heading[14] && (sin_idx == '0);
            r_cos_full <= acc_cos_heading[14] && (cos_idx == '0);
            r_sin_neg  <= acc_heading[15];
            r_cos_neg  <= acc_cos_heading[15];
            r_s1_op    <= acc_op;
            r_s1_start <= s_axis_tuser;
            r_stk_q    <= stack_mem[stk_raddr];
        end
        if (stk_we) begin
            stack_mem[base_count[KAW-1:0]] <= stk_wdata;
        end
    end

    // ------------------------------------------------------------------------
    // work stage: read data arrive, update the turtle
    // ------------------------------------------------------------------------
    assign base_x     = r_s1_start ? '0 : r_x;
    assign base_y     = r_s1_start ? '0 : r_y;
    assign base_h     = r_s1_start ? r_start_heading : r_heading;
    assign base_count = r_s1_start ? '0 : r_count;

    assign sin_mag = r_sin_full ? tpsg_pkg::Q_ONE : r_sin_q;
    assign cos_mag = r_cos_full ? tpsg_pkg::Q_ONE : r_cos_q;
    assign sin_val = r_sin_neg ? -{1'b0, sin_mag} : {1'b0, sin_mag};
    assign cos_val = r_cos_neg ? -{1'b0, cos_mag} : {1'b0, cos_mag};

    assign sum_x = {base_x[31], base_x} + {{15{cos_val[17]}}, cos_val};
    assign sum_y = {base_y[31], base_y} + {{15{sin_val[17]}}, sin_val};
    // clamp on signed overflow
    assign to_x  = (sum_x[32] != sum_x[31]) ? (sum_x[32] ? 32'h8000_0000 : 32'h7FFF_FFFF)
                                            : sum_x[31:0];
    assign to_y  = (sum_y[32] != sum_y[31]) ? (sum_y[32] ? 32'h8000_0000 : 32'h7FFF_FFFF)
                                            : sum_y[31:0];

    assign stk_wdata = '{x: base_x, y: base_y, h: base_h};

    always_comb begin
        n_x        = base_x;
        n_y        = base_y;
        n_heading  = base_h;
        n_count    = base_count;
        stk_we     = 1'b0;
        n_out_kind = tpsg_pkg::KIND_NONE;
        n_out_data = '0;
        unique case (r_s1_op)
            tpsg_pkg::OP_LEFT:  n_heading = base_h + r_turn_step;
            tpsg_pkg::OP_RIGHT: n_heading = base_h - r_turn_step;
            tpsg_pkg::OP_PUSH: begin
                if (base_count < KCW'(tpsg_pkg::STACK_DEPTH)) begin
                    stk_we  = s1_fire;
                    n_count = base_count + KCW'(1);
                end else begin
                    n_out_kind = tpsg_pkg::KIND_DROPPED;
                end
            end
            tpsg_pkg::OP_POP: begin
                if (base_count != '0) begin
                    n_count   = base_count - KCW'(1);
                    n_x       = r_stk_q.x;
                    n_y       = r_stk_q.y;
                    n_heading = r_stk_q.h;
                end
            end
            tpsg_pkg::OP_DRAW: begin
                n_x        = to_x;
                n_y        = to_y;
                n_out_kind = tpsg_pkg::KIND_SEGMENT;
                n_out_data = {to_y, to_x, base_y, base_x};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x         <= '0;
            r_y         <= '0;
            r_heading   <= '0;
            r_count     <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_fire) begin
                r_x       <= n_x;
                r_y       <= n_y;
                r_heading <= n_heading;
                r_count   <= n_count;
            end
            // hold the parked item until the output register frees
            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out_kind <= n_out_kind;
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tdata  = r_out_data;

endmodule
